[rtl/core/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the battery level smoother core.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  // Default values of the top-level parameters.
  localparam int TIME_BITS_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Fixed field widths.
  localparam int LEVEL_BITS   = 7;
  localparam int ALPHA_BITS   = 16;
  localparam int COUNT_BITS   = 4;
  localparam int WARMUP_BITS  = 3;
  localparam int FAST_BITS    = 16;
  localparam int SLOW_BITS    = 24;
  localparam int DELAY_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  // Largest legal sample and saturation point of the read counter.
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX      = 7'd100;
  localparam logic [COUNT_BITS-1:0] READ_COUNT_MAX = 4'd15;

  // Register reset values.
  localparam logic [DELAY_BITS-1:0]  STARTUP_DELAY_RESET = 16'd3000;
  localparam logic [FAST_BITS-1:0]   FAST_INTERVAL_RESET = 16'd3000;
  localparam logic [SLOW_BITS-1:0]   SLOW_INTERVAL_RESET = 24'd30000;
  localparam logic [WARMUP_BITS-1:0] WARMUP_READS_RESET  = 3'd3;
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET         = 16'd9830;
  localparam logic [LEVEL_BITS-1:0]  RISE_MARGIN_RESET   = 7'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STARTUP_DELAY = 3'd0,
    REG_FAST_INTERVAL = 3'd1,
    REG_SLOW_INTERVAL = 3'd2,
    REG_WARMUP_READS  = 3'd3,
    REG_ALPHA         = 3'd4,
    REG_RISE_MARGIN   = 3'd5
  } bls_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [DELAY_BITS-1:0]  startup_delay_ms;
    logic [FAST_BITS-1:0]   fast_interval_ms;
    logic [SLOW_BITS-1:0]   slow_interval_ms;
    logic [WARMUP_BITS-1:0] warmup_reads;
    logic [ALPHA_BITS-1:0]  alpha_q16;
    logic [LEVEL_BITS-1:0]  rise_margin;
  } bls_cfg_t;

endpackage

`default_nettype wire

[rtl/core/bls_update.sv]
// ----------------------------------------------------------------------------
// bls_update
// Combinational state update for one poll tick: poll gating, warm-up load,
// exponential average and display hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_update #(
  parameter int TIME_BITS = bls_pkg::TIME_BITS_DEFAULT,
  parameter int FRAC_BITS = bls_pkg::FRAC_BITS_DEFAULT
) (
  input  wire bls_pkg::bls_cfg_t                        cfg,
  input  wire logic [TIME_BITS-1:0]                     now_ms,
  input  wire logic [bls_pkg::LEVEL_BITS-1:0]           level_percent,
  input  wire logic                                     level_valid,
  input  wire logic [TIME_BITS-1:0]                     last_poll_time,
  input  wire logic [bls_pkg::COUNT_BITS-1:0]           read_count,
  input  wire logic [bls_pkg::LEVEL_BITS+FRAC_BITS-1:0] average_q16,
  input  wire logic [bls_pkg::LEVEL_BITS-1:0]           display_value,
  input  wire logic                                     display_known,
  output logic      [TIME_BITS-1:0]                     last_poll_time_next,
  output logic      [bls_pkg::COUNT_BITS-1:0]           read_count_next,
  output logic      [bls_pkg::LEVEL_BITS+FRAC_BITS-1:0] average_q16_next,
  output logic      [bls_pkg::LEVEL_BITS-1:0]           display_value_next,
  output logic                                          display_known_next,
  output logic                                          changed
);

  localparam int LB    = bls_pkg::LEVEL_BITS;
  localparam int AB    = bls_pkg::ALPHA_BITS;
  localparam int AVG_W = LB + FRAC_BITS;
  localparam int CMP_W = (TIME_BITS > bls_pkg::SLOW_BITS) ? TIME_BITS : bls_pkg::SLOW_BITS;
  localparam int ACC_W = AVG_W + AB + 2;

  logic                    sample_ok;
  logic                    poll_ok;
  logic [TIME_BITS-1:0]    elapsed;
  logic [CMP_W-1:0]        interval;
  logic [bls_pkg::COUNT_BITS-1:0] count_inc;
  logic                    load_direct;
  logic [AVG_W-1:0]        level_q;
  logic signed [AVG_W:0]   delta;
  logic signed [ACC_W-1:0] product;
  logic signed [ACC_W-1:0] acc;
  logic [AVG_W-1:0]        avg_new;
  logic [AVG_W:0]          avg_round;
  logic [LB-1:0]           smooth;
  logic                    rise_ok;

  // Poll gating: startup delay, then the warm-up or steady interval.
  assign sample_ok = level_valid && (level_percent <= bls_pkg::LEVEL_MAX);
  assign elapsed   = now_ms - last_poll_time;
  assign interval  = (read_count < {1'b0, cfg.warmup_reads}) ?
                     CMP_W'(cfg.fast_interval_ms) : CMP_W'(cfg.slow_interval_ms);
  assign poll_ok   = (CMP_W'(now_ms) >= CMP_W'(cfg.startup_delay_ms)) &&
                     (CMP_W'(elapsed) >= interval);

  // Saturating count of valid reads, and the direct-load decision.
  assign count_inc   = (read_count < bls_pkg::READ_COUNT_MAX) ?
                       read_count + bls_pkg::COUNT_BITS'(1) : read_count;
  assign load_direct = (count_inc <= {1'b0, cfg.warmup_reads}) || !display_known;

  // Average update as avg + (level - avg) * alpha, rounded half up.
  assign level_q = {level_percent, {FRAC_BITS{1'b0}}};
  assign delta   = $signed({1'b0, level_q}) - $signed({1'b0, average_q16});
  assign product = ACC_W'(delta) * ACC_W'($signed({1'b0, cfg.alpha_q16}));
  assign acc     = $signed({2'b00, average_q16, {AB{1'b0}}}) + product +
                   $signed({{(ACC_W-AB){1'b0}}, 1'b1, {(AB-1){1'b0}}});
  assign avg_new = acc[AVG_W+AB-1:AB];

  // Rounded average and rise hysteresis.
  assign avg_round = {1'b0, avg_new} + {{(LB+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign smooth    = avg_round[AVG_W-1:FRAC_BITS];
  assign rise_ok   = {1'b0, smooth} >= ({1'b0, display_value} + {1'b0, cfg.rise_margin});

  // Next state selection.
  always_comb begin
    last_poll_time_next = last_poll_time;
    read_count_next     = read_count;
    average_q16_next    = average_q16;
    display_value_next  = display_value;
    display_known_next  = display_known;
    changed             = 1'b0;
    if (poll_ok) begin
      last_poll_time_next = now_ms;
      if (sample_ok) begin
        read_count_next = count_inc;
        if (load_direct) begin
          average_q16_next   = level_q;
          display_value_next = level_percent;
          display_known_next = 1'b1;
          changed            = !display_known || (display_value != level_percent);
        end else begin
          average_q16_next = avg_new;
          if ((smooth != display_value) && ((smooth < display_value) || rise_ok)) begin
            display_value_next = smooth;
            changed            = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/battery_level_smoother_core.sv]
// ----------------------------------------------------------------------------
// battery_level_smoother_core
// Battery level smoother: exponential moving average with rise hysteresis,
// one result beat for every poll tick beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser poll tick
//  m_*       out        m_tvalid m_tready m_tdata m_tuser display result
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data register write
//
//  A tick beat is registered in the input register, updated against the state
//  combinationally and written to the result register; one beat per cycle is
//  sustained while m_tready stays high. The state loop (poll time, count,
//  average, display) is closed through a single 24x17 multiply in the update.
//  Reset clears the state and loads the register defaults.
//  A stalled result register holds its beat while one more tick waits in the
//  input register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_smoother_core #(
  parameter int TIME_BITS = bls_pkg::TIME_BITS_DEFAULT,
  parameter int FRAC_BITS = bls_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // [TIME_BITS-1:0] now_ms, [TIME_BITS+6:TIME_BITS] level_percent, zero pad
  input  wire logic [((TIME_BITS+bls_pkg::LEVEL_BITS+7)/8)*8-1:0] s_tdata,
  // [0] level_valid
  input  wire logic [0:0]                            s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // [6:0] shown_percent, [7] zero pad
  output logic [7:0]                                 m_tdata,
  // [0] shown_valid, [1] shown_changed
  output logic [1:0]                                 m_tuser,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bls_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [bls_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int LB    = bls_pkg::LEVEL_BITS;
  localparam int AVG_W = LB + FRAC_BITS;

  bls_pkg::bls_cfg_t cfg;

  // Input register.
  logic                 in_valid;
  logic [TIME_BITS-1:0] in_now;
  logic [LB-1:0]        in_level;
  logic                 in_flag;

  // State.
  logic [TIME_BITS-1:0]           last_poll_time;
  logic [bls_pkg::COUNT_BITS-1:0] read_count;
  logic [AVG_W-1:0]               average_q16;
  logic [LB-1:0]                  display_value;
  logic                           display_known;

  logic [TIME_BITS-1:0]           last_poll_time_next;
  logic [bls_pkg::COUNT_BITS-1:0] read_count_next;
  logic [AVG_W-1:0]               average_q16_next;
  logic [LB-1:0]                  display_value_next;
  logic                           display_known_next;
  logic                           changed_next;

  // Result register.
  logic          out_valid;
  logic [LB-1:0] out_percent;
  logic          out_known;
  logic          out_changed;

  logic advance;

  // Handshakes: the tick moves on when the result register is free or is being read out.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_delay_ms <= bls_pkg::STARTUP_DELAY_RESET;
      cfg.fast_interval_ms <= bls_pkg::FAST_INTERVAL_RESET;
      cfg.slow_interval_ms <= bls_pkg::SLOW_INTERVAL_RESET;
      cfg.warmup_reads     <= bls_pkg::WARMUP_READS_RESET;
      cfg.alpha_q16        <= bls_pkg::ALPHA_RESET;
      cfg.rise_margin      <= bls_pkg::RISE_MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bls_pkg::REG_STARTUP_DELAY: cfg.startup_delay_ms <= cfg_data[bls_pkg::DELAY_BITS-1:0];
        bls_pkg::REG_FAST_INTERVAL: cfg.fast_interval_ms <= cfg_data[bls_pkg::FAST_BITS-1:0];
        bls_pkg::REG_SLOW_INTERVAL: cfg.slow_interval_ms <= cfg_data[bls_pkg::SLOW_BITS-1:0];
        bls_pkg::REG_WARMUP_READS:  cfg.warmup_reads     <= cfg_data[bls_pkg::WARMUP_BITS-1:0];
        bls_pkg::REG_ALPHA:         cfg.alpha_q16        <= cfg_data[bls_pkg::ALPHA_BITS-1:0];
        bls_pkg::REG_RISE_MARGIN:   cfg.rise_margin      <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture a tick beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now   <= s_tdata[TIME_BITS-1:0];
      in_level <= s_tdata[TIME_BITS+LB-1:TIME_BITS];
      in_flag  <= s_tuser[0];
    end
  end

  // Update logic.
  bls_update #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_update (
    .cfg                 (cfg),
    .now_ms              (in_now),
    .level_percent       (in_level),
    .level_valid         (in_flag),
    .last_poll_time      (last_poll_time),
    .read_count          (read_count),
    .average_q16         (average_q16),
    .display_value       (display_value),
    .display_known       (display_known),
    .last_poll_time_next (last_poll_time_next),
    .read_count_next     (read_count_next),
    .average_q16_next    (average_q16_next),
    .display_value_next  (display_value_next),
    .display_known_next  (display_known_next),
    .changed             (changed_next)
  );

  // State registers advance with the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time <= '0;
      read_count     <= '0;
      average_q16    <= '0;
      display_value  <= '0;
      display_known  <= 1'b0;
    end else if (advance) begin
      last_poll_time <= last_poll_time_next;
      read_count     <= read_count_next;
      average_q16    <= average_q16_next;
      display_value  <= display_value_next;
      display_known  <= display_known_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_percent <= display_known_next ? display_value_next : '0;
      out_known   <= display_known_next;
      out_changed <= changed_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_percent};
  assign m_tuser  = {out_changed, out_known};

`ifndef NO_ASSERTIONS
  // State is only touched by a tick moving into the result register.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(read_count) && $stable(average_q16))
    else $error("state changed without a tick");

  // Once a valid sample has been shown, the display stays known.
  a_known_sticky: assert property (@(posedge clk) disable iff (rst)
    display_known |=> display_known)
    else $error("display lost its known flag");

  // The average never leaves the range of a percentage.
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    average_q16 <= {bls_pkg::LEVEL_MAX, {FRAC_BITS{1'b0}}})
    else $error("average above one hundred percent");

  // A change can only be reported on a known display.
  a_changed_known: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("change reported on an unknown display");

  // The display value stays a legal percentage.
  a_display_range: assert property (@(posedge clk) disable iff (rst)
    display_value <= bls_pkg::LEVEL_MAX)
    else $error("display above one hundred percent");
`endif

endmodule

`default_nettype wire

[tb/battery_level_smoother_core_test.sv]
// ----------------------------------------------------------------------------
// battery_level_smoother_core_test
// Self-checking testbench for the battery level smoother core. Poll tick beats
// are queued by a stimulus process and sent by a clocked driver. Each accepted
// tick is run through a local model of the smoother. A clocked monitor checks
// every result beat against the oldest predicted display value. Register
// settings change between phases, once the core has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module battery_level_smoother_core_test;
  import bls_pkg::*;

  localparam int TIME_W = TIME_BITS_DEFAULT;
  localparam int FRAC_W = FRAC_BITS_DEFAULT;
  localparam int TICK_W = ((TIME_W + LEVEL_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;

  // One poll tick and one display result.
  typedef struct {
    logic [TIME_W-1:0]     now;
    logic [LEVEL_BITS-1:0] level;
    logic                  valid;
  } tick_t;

  typedef struct {
    logic [LEVEL_BITS-1:0] percent;
    logic                  known;
    logic                  changed;
  } shown_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [TICK_W-1:0] s_tdata = '0;   // now_ms, level_percent, zero pad
  logic [0:0]        s_tuser = '0;   // level_valid
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // shown_percent, zero pad
  logic [1:0]        m_tuser;        // shown_valid, shown_changed
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  bls_reg_t                 cfg_index = REG_STARTUP_DELAY;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  battery_level_smoother_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Ticks waiting to be sent and display results waiting to arrive.
  tick_t  tick_pending[$];
  shown_t shown_expected[$];
  tick_t  tick_on_bus;
  int     send_idle = 0;
  int     recv_idle = 0;
  int     errors = 0;
  int     cycles = 0;

  // Local copy of the registers and of the smoother state.
  bls_cfg_t              reg_shadow;
  logic [TIME_W-1:0]     last_poll = '0;
  logic [COUNT_BITS-1:0] poll_count = '0;
  logic [22:0]           avg_q16 = '0;
  logic [LEVEL_BITS-1:0] shown_level = '0;
  logic                  shown_known = 1'b0;

  // Stimulus generator state.
  logic [TIME_W-1:0] gen_time = '0;
  int                gen_level = 50;

  // Apply one accepted tick to the smoother state and queue its display result.
  task automatic smooth_tick(input tick_t tk);
    logic                 sample_ok;
    logic                 chg;
    logic [TIME_W-1:0]    elapsed;
    logic [SLOW_BITS-1:0] interval;
    logic [63:0]          acc;
    logic [63:0]          rounded;
    logic [63:0]          level_w;
    shown_t               res;
    sample_ok = tk.valid && (tk.level <= LEVEL_MAX);
    chg = 1'b0;
    if (tk.now >= reg_shadow.startup_delay_ms) begin
      interval = (poll_count < reg_shadow.warmup_reads) ? reg_shadow.fast_interval_ms
                                                        : reg_shadow.slow_interval_ms;
      elapsed = tk.now - last_poll;
      if (elapsed >= interval) begin
        last_poll = tk.now;
        if (sample_ok) begin
          if (poll_count != READ_COUNT_MAX) poll_count = poll_count + COUNT_BITS'(1);
          if (poll_count <= reg_shadow.warmup_reads || !shown_known) begin
            // Warm-up or first valid sample: load directly.
            chg = !shown_known || (shown_level != tk.level);
            avg_q16 = 23'(tk.level) << FRAC_W;
            shown_level = tk.level;
            shown_known = 1'b1;
          end else begin
            // Exponential average, rounded half up, then the rise hysteresis.
            level_w = 64'(tk.level) << FRAC_W;
            acc = 64'(avg_q16) * (64'd65536 - 64'(reg_shadow.alpha_q16))
                + level_w * 64'(reg_shadow.alpha_q16) + 64'd32768;
            avg_q16 = 23'(acc >> 16);
            rounded = (64'(avg_q16) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
            if (rounded != 64'(shown_level) &&
                (rounded < 64'(shown_level) ||
                 rounded >= 64'(shown_level) + 64'(reg_shadow.rise_margin))) begin
              shown_level = rounded[LEVEL_BITS-1:0];
              chg = 1'b1;
            end
          end
        end
      end
    end
    res.percent = shown_known ? shown_level : '0;
    res.known   = shown_known;
    res.changed = chg;
    shown_expected.push_back(res);
  endtask

  // Driver: predict each accepted beat, then present the next pending tick.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) smooth_tick(tick_on_bus);
      if (!s_tvalid || s_tready) begin
        if (tick_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          tick_on_bus = tick_pending.pop_front();
          s_tdata  <= {{(TICK_W - TIME_W - LEVEL_BITS){1'b0}}, tick_on_bus.level,
                       tick_on_bus.now};
          s_tuser  <= tick_on_bus.valid;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    shown_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (shown_expected.size() == 0) begin
          $display("%0t: unexpected result beat, actual percent %0d valid %0b changed %0b",
                   $time, m_tdata[6:0], m_tuser[0], m_tuser[1]);
          errors++;
        end else begin
          want = shown_expected.pop_front();
          if (m_tdata[6:0] !== want.percent) begin
            $display("%0t: shown_percent mismatch, expected %0d, actual %0d",
                     $time, want.percent, m_tdata[6:0]);
            errors++;
          end
          if (m_tuser[0] !== want.known) begin
            $display("%0t: shown_valid mismatch, expected %0b, actual %0b",
                     $time, want.known, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== want.changed) begin
            $display("%0t: shown_changed mismatch, expected %0b, actual %0b",
                     $time, want.changed, m_tuser[1]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("battery_level_smoother_core_test NOT OK");
      $finish;
    end
  end

  // Write one register through the configuration channel and mirror it.
  task automatic write_reg(input bls_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STARTUP_DELAY: reg_shadow.startup_delay_ms = val[DELAY_BITS-1:0];
      REG_FAST_INTERVAL: reg_shadow.fast_interval_ms = val[FAST_BITS-1:0];
      REG_SLOW_INTERVAL: reg_shadow.slow_interval_ms = val[SLOW_BITS-1:0];
      REG_WARMUP_READS:  reg_shadow.warmup_reads     = val[WARMUP_BITS-1:0];
      REG_ALPHA:         reg_shadow.alpha_q16        = val[ALPHA_BITS-1:0];
      REG_RISE_MARGIN:   reg_shadow.rise_margin      = val[LEVEL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic [TIME_W-1:0] now, input int lvl, input logic vld);
    tick_t tk;
    tk.now   = now;
    tk.level = lvl[LEVEL_BITS-1:0];
    tk.valid = vld;
    tick_pending.push_back(tk);
    gen_time = now;
  endtask

  // Wait until every queued tick has produced its result. The
  // check runs on the falling edge, after all rising-edge updates settled.
  task automatic drain;
    do @(negedge clk);
    while (tick_pending.size() != 0 || s_tvalid || shown_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register set for a random phase: high extremes, low extremes or random.
  task automatic random_config(input int sel);
    if (sel == 0) begin
      write_reg(REG_STARTUP_DELAY, 24'd65535);
      write_reg(REG_FAST_INTERVAL, 24'd65535);
      write_reg(REG_SLOW_INTERVAL, 24'hFFFFFF);
      write_reg(REG_WARMUP_READS, 24'd7);
      write_reg(REG_ALPHA, 24'd65535);
      write_reg(REG_RISE_MARGIN, 24'd100);
    end else if (sel == 1) begin
      write_reg(REG_STARTUP_DELAY, 24'd0);
      write_reg(REG_FAST_INTERVAL, 24'd0);
      write_reg(REG_SLOW_INTERVAL, 24'd0);
      write_reg(REG_WARMUP_READS, 24'd1);
      write_reg(REG_ALPHA, 24'd1);
      write_reg(REG_RISE_MARGIN, 24'd1);
    end else begin
      write_reg(REG_STARTUP_DELAY, 24'($urandom_range(20000, 0)));
      write_reg(REG_FAST_INTERVAL, 24'($urandom_range(5000, 0)));
      write_reg(REG_SLOW_INTERVAL, 24'($urandom_range(60000, 0)));
      write_reg(REG_WARMUP_READS, 24'($urandom_range(7, 1)));
      write_reg(REG_ALPHA, 24'($urandom_range(65535, 1)));
      write_reg(REG_RISE_MARGIN, 24'($urandom_range(100, 1)));
    end
  endtask

  // Random ticks: mostly spaced to pass the interval, some on its boundary,
  // some arbitrary jumps across the time wrap, the rest too close to count.
  task automatic random_ticks(input int polls);
    int                made;
    int                pick;
    int                lvl;
    logic [TIME_W-1:0] advance;
    logic [TIME_W-1:0] lo_iv;
    logic [TIME_W-1:0] hi_iv;
    lo_iv = (reg_shadow.fast_interval_ms < reg_shadow.slow_interval_ms) ?
            reg_shadow.fast_interval_ms : reg_shadow.slow_interval_ms;
    hi_iv = (reg_shadow.fast_interval_ms > reg_shadow.slow_interval_ms) ?
            reg_shadow.fast_interval_ms : reg_shadow.slow_interval_ms;
    made = 0;
    while (made < polls) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        advance = hi_iv + $urandom_range(40, 0);
        made++;
      end else if (pick < 70) begin
        case ($urandom_range(3, 0))
          0: advance = reg_shadow.fast_interval_ms - 1;
          1: advance = reg_shadow.fast_interval_ms;
          2: advance = reg_shadow.slow_interval_ms - 1;
          default: advance = reg_shadow.slow_interval_ms;
        endcase
        made++;
      end else if (pick < 78) begin
        advance = $urandom;
        made++;
      end else begin
        advance = (lo_iv == 0) ? '0 : $urandom_range(lo_iv - 1, 0);
      end
      // Level: a slow walk most of the time, sometimes any value.
      pick = $urandom_range(99);
      if (pick < 60) begin
        gen_level = gen_level + int'($urandom_range(10, 0)) - 5;
        if (gen_level < 0) gen_level = 0;
        if (gen_level > 100) gen_level = 100;
        lvl = gen_level;
      end else if (pick < 85) begin
        lvl = $urandom_range(100, 0);
      end else begin
        lvl = $urandom_range(127, 101);
      end
      push_tick(gen_time + advance, lvl, $urandom_range(9, 0) != 0);
    end
  endtask

  // Main sequence: reset, directed phases, then random phases.
  initial begin
    reg_shadow.startup_delay_ms = STARTUP_DELAY_RESET;
    reg_shadow.fast_interval_ms = FAST_INTERVAL_RESET;
    reg_shadow.slow_interval_ms = SLOW_INTERVAL_RESET;
    reg_shadow.warmup_reads     = WARMUP_READS_RESET;
    reg_shadow.alpha_q16        = ALPHA_RESET;
    reg_shadow.rise_margin      = RISE_MARGIN_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle = 36;
    recv_idle = 67;

    // Reset defaults: ticks before the startup delay, an invalid first poll,
    // and a tick too close to it.
    push_tick(32'd0, 50, 1'b1);
    push_tick(32'd2999, 50, 1'b1);
    push_tick(32'd3000, 0, 1'b0);
    push_tick(32'd5999, 60, 1'b1);
    drain();

    // No warm-up, zero alpha and zero rise margin; an over-range sample.
    write_reg(REG_WARMUP_READS, 24'd0);
    write_reg(REG_ALPHA, 24'd0);
    write_reg(REG_RISE_MARGIN, 24'd0);
    write_reg(REG_STARTUP_DELAY, 24'd0);
    push_tick(32'd35999, 120, 1'b1);
    push_tick(32'd65999, 100, 1'b1);
    push_tick(32'd95999, 0, 1'b1);
    drain();

    // Longest warm-up with a zero fast interval, then the full-scale rise
    // that the widest margin holds back, and a fall.
    write_reg(REG_WARMUP_READS, 24'd7);
    write_reg(REG_ALPHA, 24'd65535);
    write_reg(REG_RISE_MARGIN, 24'd100);
    write_reg(REG_FAST_INTERVAL, 24'd0);
    write_reg(REG_SLOW_INTERVAL, 24'hFFFFFF);
    push_tick(32'd95999, 0, 1'b1);
    push_tick(32'd95999, 100, 1'b1);
    push_tick(32'd95999, 37, 1'b1);
    push_tick(32'd95999, 1, 1'b1);
    push_tick(32'd95999, 99, 1'b1);
    push_tick(32'd95999, 77, 1'b1);
    push_tick(32'd95999, 5, 1'b1);
    push_tick(32'd95999, 100, 1'b1);
    push_tick(32'd95999 + 32'hFFFFFF, 100, 1'b1);
    push_tick(32'd95999 + 32'h1FFFFFE, 0, 1'b1);
    drain();

    // Elapsed time across the wrap of the millisecond counter.
    write_reg(REG_SLOW_INTERVAL, 24'd100);
    write_reg(REG_WARMUP_READS, 24'd1);
    write_reg(REG_ALPHA, 24'd1);
    write_reg(REG_RISE_MARGIN, 24'd1);
    write_reg(REG_FAST_INTERVAL, 24'd65535);
    push_tick(32'hFFFF_FFF0, 50, 1'b1);
    push_tick(32'h0000_0054, 127, 1'b1);
    push_tick(32'h0000_0063, 64, 1'b1);
    drain();

    // Random phases, each started from an idle core.
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 3) begin
        send_idle = 67;
        recv_idle = 36;
      end else if (phase == 5) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_config(phase);
      random_ticks(156);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("battery_level_smoother_core_test OK");
    end else begin
      $display("battery_level_smoother_core_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bls_pkg.sv
rtl/core/bls_update.sv
rtl/core/battery_level_smoother_core.sv
tb/battery_level_smoother_core_test.sv
